/* rtl/core/pfd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, stage codes and pipeline payload type of the pixel feature distance core.
package pfd_pkg;

	localparam int CH_W    = 8;
	localparam int SUM_W   = 10;
	localparam int LANES   = 6;   // three input ratios, then three reference ratios
	localparam int NSTAGE  = 12;

	localparam int IN_W    = 3 * CH_W;
	localparam int OUT_W   = 128;
	localparam int CFG_IW  = 2;

	localparam logic [SUM_W-1:0] SUM_LOW   = 10'd6;
	localparam logic [SUM_W-1:0] SUM_HIGH  = 10'd672;
	localparam logic [CH_W-1:0]  RATIO_MAX = 8'd255;

	// Configuration register indexes.
	localparam logic [CFG_IW-1:0] REG_RED   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_GREEN = 2'd1;
	localparam logic [CFG_IW-1:0] REG_BLUE  = 2'd2;

	// Stage codes.
	localparam int ST_SQV    = 2;
	localparam int ST_SQD    = 3;
	localparam int ST_DSUM   = 4;
	localparam int DIV_FIRST = 2;
	localparam int DIV_LAST  = 9;
	localparam int ST_RATIO  = 10;
	localparam int ST_SQR    = 11;
	localparam int ST_OUT    = 12;

	// Bit offsets of the result fields in the master tdata.
	localparam int O_DRG = 0;
	localparam int O_DRB = 9;
	localparam int O_DGB = 18;
	localparam int O_RR  = 27;
	localparam int O_RG  = 35;
	localparam int O_RB  = 43;
	localparam int O_DV  = 51;
	localparam int O_DD  = 69;
	localparam int O_DR  = 89;
	localparam int O_DT  = 107;

	typedef struct packed {
		logic [LANES-1:0][CH_W-1:0]  num_lo;
		logic [LANES-1:0][SUM_W-1:0] rem;
		logic [LANES-1:0][CH_W-1:0]  quo;
		logic [SUM_W-1:0]            sum_px;
		logic [SUM_W-1:0]            sum_rf;
		logic                        dark_px;
		logic                        bright_px;
		logic                        dark_rf;
		logic                        bright_rf;
		logic [2:0][8:0]             diff_px;
		logic [2:0][8:0]             dval;
		logic [2:0][9:0]             ddif;
		logic [2:0][15:0]            sqv;
		logic [2:0][17:0]            sqd;
		logic [17:0]                 dist_value;
		logic [19:0]                 dist_diff;
		logic [2:0][7:0]             ratio_px;
		logic [2:0][8:0]             rdel;
		logic [2:0][15:0]            sqr;
		logic [17:0]                 dist_ratio;
		logic [20:0]                 dist_total;
	} pl_t;

endpackage

/* rtl/core/pixel_feature_distance_core.sv */
`timescale 1ns / 1ps
// Top level of the pixel feature distance core: a twelve-stage feature and distance pipeline.
//
// The core takes one RGB pixel per clock while the output side does not stall and returns its
// channel differences, its three chromaticity ratios and its squared distances to a reference
// color held in configuration. The depth comes from the eight one-bit steps of the restoring
// dividers that form the ratios; the value and difference distances are squared and summed
// alongside the first steps, and the ratio squaring and summing stages follow them. Each
// stage holds its item until the next stage can take it, so bubbles close up and a stall on
// the output loses nothing. Write the reference registers only while no pixel is in flight.
module pixel_feature_distance_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// in_red[7:0], in_green[15:8], in_blue[23:16]
	input  logic [pfd_pkg::IN_W-1:0]      s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// diff_rg[8:0], diff_rb[17:9], diff_gb[26:18], ratio_r[34:27], ratio_g[42:35],
	// ratio_b[50:43], dist_value[68:51], dist_diff[88:69], dist_ratio[106:89],
	// dist_total[127:107]
	output logic [pfd_pkg::OUT_W-1:0]     m_tdata,
	input  logic                          cfg_we,
	input  logic [pfd_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [pfd_pkg::CH_W-1:0]      cfg_data
);

	logic [pfd_pkg::CH_W-1:0] ref_red_q, ref_green_q, ref_blue_q;

	pfd_pkg::pl_t pipe_s [1:pfd_pkg::NSTAGE];
	pfd_pkg::pl_t nxt    [1:pfd_pkg::NSTAGE];
	logic [pfd_pkg::NSTAGE:1]   vld_s;
	logic [pfd_pkg::NSTAGE:1]   vin;
	logic [pfd_pkg::NSTAGE+1:1] rdy;

	function automatic logic [8:0] sub9(input logic [7:0] a, input logic [7:0] b);
		sub9 = {1'b0, a} - {1'b0, b};
	endfunction

	function automatic pfd_pkg::pl_t entry(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] rr, input logic [7:0] rg, input logic [7:0] rb);
		pfd_pkg::pl_t p;
		logic [2:0][7:0] ch;
		logic [2:0][8:0] drf;
		logic [15:0]     num;
		p = '0;
		ch[0] = r;  ch[1] = g;  ch[2] = b;
		for (int l = 0; l < 3; l++) begin
			num = {ch[l], 8'h00} - {8'h00, ch[l]};
			p.rem[l]    = {2'b00, num[15:8]};
			p.num_lo[l] = num[7:0];
		end
		ch[0] = rr; ch[1] = rg; ch[2] = rb;
		for (int l = 0; l < 3; l++) begin
			num = {ch[l], 8'h00} - {8'h00, ch[l]};
			p.rem[l+3]    = {2'b00, num[15:8]};
			p.num_lo[l+3] = num[7:0];
		end
		p.sum_px    = {2'b00, r} + {2'b00, g} + {2'b00, b} + 10'd1;
		p.sum_rf    = {2'b00, rr} + {2'b00, rg} + {2'b00, rb} + 10'd1;
		p.dark_px   = p.sum_px < pfd_pkg::SUM_LOW;
		p.bright_px = p.sum_px >= pfd_pkg::SUM_HIGH;
		p.dark_rf   = p.sum_rf < pfd_pkg::SUM_LOW;
		p.bright_rf = p.sum_rf >= pfd_pkg::SUM_HIGH;
		p.diff_px[0] = sub9(r, g);
		p.diff_px[1] = sub9(r, b);
		p.diff_px[2] = sub9(g, b);
		drf[0] = sub9(rr, rg);
		drf[1] = sub9(rr, rb);
		drf[2] = sub9(rg, rb);
		p.dval[0] = sub9(r, rr);
		p.dval[1] = sub9(g, rg);
		p.dval[2] = sub9(b, rb);
		for (int l = 0; l < 3; l++) begin
			p.ddif[l] = {p.diff_px[l][8], p.diff_px[l]} - {drf[l][8], drf[l]};
		end
		return p;
	endfunction

	// One restoring division step on every lane: the remainder stays below the divisor.
	function automatic pfd_pkg::pl_t div_step(input pfd_pkg::pl_t p);
		pfd_pkg::pl_t q;
		logic [10:0] trial;
		logic [10:0] dv;
		q = p;
		for (int l = 0; l < pfd_pkg::LANES; l++) begin
			trial = {p.rem[l], p.num_lo[l][7]};
			dv    = (l < 3) ? {1'b0, p.sum_px} : {1'b0, p.sum_rf};
			if (trial >= dv) begin
				q.rem[l] = 10'(trial - dv);
				q.quo[l] = {p.quo[l][6:0], 1'b1};
			end else begin
				q.rem[l] = trial[9:0];
				q.quo[l] = {p.quo[l][6:0], 1'b0};
			end
			q.num_lo[l] = {p.num_lo[l][6:0], 1'b0};
		end
		return q;
	endfunction

	function automatic pfd_pkg::pl_t stage_fn(input int k, input pfd_pkg::pl_t p);
		pfd_pkg::pl_t q;
		logic signed [17:0] pv;
		logic signed [19:0] pd;
		logic [7:0]         rp, rr;
		q = p;
		if (k >= pfd_pkg::DIV_FIRST && k <= pfd_pkg::DIV_LAST) begin
			q = div_step(p);
		end
		case (k)
			pfd_pkg::ST_SQV: begin
				for (int l = 0; l < 3; l++) begin
					pv = $signed(p.dval[l]) * $signed(p.dval[l]);
					q.sqv[l] = pv[15:0];
				end
			end
			pfd_pkg::ST_SQD: begin
				for (int l = 0; l < 3; l++) begin
					pd = $signed(p.ddif[l]) * $signed(p.ddif[l]);
					q.sqd[l] = pd[17:0];
				end
			end
			pfd_pkg::ST_DSUM: begin
				q.dist_value = {2'b00, p.sqv[0]} + {2'b00, p.sqv[1]} + {2'b00, p.sqv[2]};
				q.dist_diff  = {2'b00, p.sqd[0]} + {2'b00, p.sqd[1]} + {2'b00, p.sqd[2]};
			end
			pfd_pkg::ST_RATIO: begin
				for (int l = 0; l < 3; l++) begin
					rp = p.dark_px ? 8'd0 : (p.bright_px ? pfd_pkg::RATIO_MAX : p.quo[l]);
					rr = p.dark_rf ? 8'd0 : (p.bright_rf ? pfd_pkg::RATIO_MAX : p.quo[l+3]);
					q.ratio_px[l] = rp;
					q.rdel[l]     = sub9(rp, rr);
				end
			end
			pfd_pkg::ST_SQR: begin
				for (int l = 0; l < 3; l++) begin
					pv = $signed(p.rdel[l]) * $signed(p.rdel[l]);
					q.sqr[l] = pv[15:0];
				end
			end
			pfd_pkg::ST_OUT: begin
				q.dist_ratio = {2'b00, p.sqr[0]} + {2'b00, p.sqr[1]} + {2'b00, p.sqr[2]};
				q.dist_total = {3'b000, p.dist_value} + {1'b0, p.dist_diff}
					+ {3'b000, {2'b00, p.sqr[0]} + {2'b00, p.sqr[1]} + {2'b00, p.sqr[2]}};
			end
			default: begin
			end
		endcase
		return q;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_red_q   <= '0;
			ref_green_q <= '0;
			ref_blue_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfd_pkg::REG_RED:   ref_red_q   <= cfg_data;
				pfd_pkg::REG_GREEN: ref_green_q <= cfg_data;
				pfd_pkg::REG_BLUE:  ref_blue_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A stage takes a new request when it is empty or its own item moves on.
	always_comb begin
		rdy[pfd_pkg::NSTAGE+1] = m_tready;
		for (int k = pfd_pkg::NSTAGE; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
		vin = {vld_s[pfd_pkg::NSTAGE-1:1], s_tvalid};
	end

	always_comb begin
		nxt[1] = entry(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
			ref_red_q, ref_green_q, ref_blue_q);
		for (int k = 2; k <= pfd_pkg::NSTAGE; k++) begin
			nxt[k] = stage_fn(k, pipe_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= pfd_pkg::NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vin[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= pfd_pkg::NSTAGE; k++) begin
			if (rdy[k] && vin[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_s[pfd_pkg::NSTAGE];
	assign m_tdata  = {
		pipe_s[pfd_pkg::NSTAGE].dist_total,
		pipe_s[pfd_pkg::NSTAGE].dist_ratio,
		pipe_s[pfd_pkg::NSTAGE].dist_diff,
		pipe_s[pfd_pkg::NSTAGE].dist_value,
		pipe_s[pfd_pkg::NSTAGE].ratio_px[2],
		pipe_s[pfd_pkg::NSTAGE].ratio_px[1],
		pipe_s[pfd_pkg::NSTAGE].ratio_px[0],
		pipe_s[pfd_pkg::NSTAGE].diff_px[2],
		pipe_s[pfd_pkg::NSTAGE].diff_px[1],
		pipe_s[pfd_pkg::NSTAGE].diff_px[0]
	};

endmodule

/* rtl/core/pfd_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the pixel feature distance core and its bind.
module pfd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [pfd_pkg::OUT_W-1:0] m_tdata
);

	logic [8:0]  c_drg, c_drb, c_dgb;
	logic [7:0]  c_rr, c_rg, c_rb;
	logic [17:0] c_dv, c_dr;
	logic [19:0] c_dd;
	logic [20:0] c_dt;
	logic [9:0]  c_rsum;

	assign c_drg  = m_tdata[pfd_pkg::O_DRG +: 9];
	assign c_drb  = m_tdata[pfd_pkg::O_DRB +: 9];
	assign c_dgb  = m_tdata[pfd_pkg::O_DGB +: 9];
	assign c_rr   = m_tdata[pfd_pkg::O_RR +: 8];
	assign c_rg   = m_tdata[pfd_pkg::O_RG +: 8];
	assign c_rb   = m_tdata[pfd_pkg::O_RB +: 8];
	assign c_dv   = m_tdata[pfd_pkg::O_DV +: 18];
	assign c_dd   = m_tdata[pfd_pkg::O_DD +: 20];
	assign c_dr   = m_tdata[pfd_pkg::O_DR +: 18];
	assign c_dt   = m_tdata[pfd_pkg::O_DT +: 21];
	assign c_rsum = {2'b00, c_rr} + {2'b00, c_rg} + {2'b00, c_rb};

	// A result that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> c_dt == ({3'b000, c_dv} + {1'b0, c_dd} + {3'b000, c_dr}))
		else $error("total distance is not the sum of its parts");

	// Red-blue minus red-green is green-blue in nine-bit arithmetic.
	a_diff: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 9'(c_drb - c_drg) == c_dgb)
		else $error("channel differences disagree");

	// Truncated shares never add up past full scale unless the pixel is bright.
	a_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (c_rsum <= 10'd255)
			|| (c_rr == 8'd255 && c_rg == 8'd255 && c_rb == 8'd255))
		else $error("chromaticity ratios exceed full scale");

endmodule

bind pixel_feature_distance_core pfd_checker u_pfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* bench/pixel_feature_distance_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the pixel feature distance core with its own feature predictor.
module pixel_feature_distance_core_test;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 2 * pfd_pkg::NSTAGE + 8;
	localparam int PHASE_PIXELS = 97;
	localparam int PHASES       = 7;
	localparam logic [pfd_pkg::CFG_IW-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [8:0]  diff_rg;
		logic [8:0]  diff_rb;
		logic [8:0]  diff_gb;
		logic [7:0]  ratio_r;
		logic [7:0]  ratio_g;
		logic [7:0]  ratio_b;
		logic [17:0] dist_value;
		logic [19:0] dist_diff;
		logic [17:0] dist_ratio;
		logic [20:0] dist_total;
	} pfd_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [pfd_pkg::IN_W-1:0]   s_tdata = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [pfd_pkg::OUT_W-1:0]  m_tdata;
	logic                       cfg_we = 1'b0;
	logic [pfd_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [pfd_pkg::CH_W-1:0]   cfg_data = '0;

	// Reference color as the core should hold it.
	logic [pfd_pkg::CH_W-1:0]   ref_rgb [3];
	logic [pfd_pkg::IN_W-1:0]   pending_pixels [$];
	pfd_result_t                expected_results [$];
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;
	int                         mismatch_count = 0;
	int                         cycle_count = 0;

	pixel_feature_distance_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Features of one color: values, then pairwise differences, then ratios.
	function automatic void pixel_features(input logic [pfd_pkg::CH_W-1:0] r, g, b,
		output int feat [9]);
		int total;
		feat[0] = int'(r);
		feat[1] = int'(g);
		feat[2] = int'(b);
		feat[3] = feat[0] - feat[1];
		feat[4] = feat[0] - feat[2];
		feat[5] = feat[1] - feat[2];
		total = 1 + feat[0] + feat[1] + feat[2];
		for (int k = 0; k < 3; k++) begin
			if (total < int'(pfd_pkg::SUM_LOW))
				feat[6 + k] = 0;
			else if (total < int'(pfd_pkg::SUM_HIGH))
				feat[6 + k] = feat[k] * int'(pfd_pkg::RATIO_MAX) / total;
			else
				feat[6 + k] = int'(pfd_pkg::RATIO_MAX);
		end
	endfunction

	function automatic pfd_result_t predict_distances(input logic [pfd_pkg::IN_W-1:0] pixel);
		int px [9];
		int rf [9];
		int part [3];
		int dev;
		pfd_result_t res;
		pixel_features(pixel[7:0], pixel[15:8], pixel[23:16], px);
		pixel_features(ref_rgb[0], ref_rgb[1], ref_rgb[2], rf);
		part = '{0, 0, 0};
		for (int k = 0; k < 9; k++) begin
			dev = px[k] - rf[k];
			part[k / 3] += dev * dev;
		end
		res.diff_rg    = 9'(px[3]);
		res.diff_rb    = 9'(px[4]);
		res.diff_gb    = 9'(px[5]);
		res.ratio_r    = 8'(px[6]);
		res.ratio_g    = 8'(px[7]);
		res.ratio_b    = 8'(px[8]);
		res.dist_value = 18'(part[0]);
		res.dist_diff  = 20'(part[1]);
		res.dist_ratio = 18'(part[2]);
		res.dist_total = 21'(part[0] + part[1] + part[2]);
		return res;
	endfunction

	// Random pixels lean toward the dark and bright thresholds.
	function automatic logic [pfd_pkg::IN_W-1:0] random_pixel();
		logic [pfd_pkg::CH_W-1:0] ch [3];
		int pick;
		int slot;
		pick = $urandom_range(99);
		slot = $urandom_range(2);
		for (int k = 0; k < 3; k++) begin
			if (pick < 55)
				ch[k] = 8'($urandom);
			else if (pick < 67)
				ch[k] = 8'($urandom_range(3));
			else if (pick < 77)
				ch[k] = 8'($urandom_range(255, 200));
			else if (pick < 89)
				ch[k] = 8'd255;
			else begin
				case ($urandom_range(2))
					0: ch[k] = 8'd0;
					1: ch[k] = 8'd255;
					default: ch[k] = 8'($urandom);
				endcase
			end
		end
		// Two full channels and a third that puts the sum next to the bright threshold.
		if (pick >= 77 && pick < 89)
			ch[slot] = 8'($urandom_range(int'(pfd_pkg::SUM_HIGH),
				int'(pfd_pkg::SUM_HIGH) - 3) - 511);
		return {ch[2], ch[1], ch[0]};
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string field, input longint unsigned want, got);
		if (want !== got)
			note_mismatch($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
	endtask

	task automatic add_pixel(input logic [pfd_pkg::CH_W-1:0] r, g, b);
		pending_pixels.push_back({b, g, r});
	endtask

	task automatic write_reg(input logic [pfd_pkg::CFG_IW-1:0] idx,
		input logic [pfd_pkg::CH_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx != REG_UNUSED)
			ref_rgb[idx] = val;
	endtask

	task automatic set_reference(input logic [pfd_pkg::CH_W-1:0] r, g, b);
		write_reg(pfd_pkg::REG_RED, r);
		write_reg(pfd_pkg::REG_GREEN, g);
		write_reg(pfd_pkg::REG_BLUE, b);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_pixels.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Request driver: predicts each pixel as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_distances(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_pixels.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		pfd_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = expected_results.pop_front();
					check_field("diff_rg", want.diff_rg, m_tdata[pfd_pkg::O_DRG +: 9]);
					check_field("diff_rb", want.diff_rb, m_tdata[pfd_pkg::O_DRB +: 9]);
					check_field("diff_gb", want.diff_gb, m_tdata[pfd_pkg::O_DGB +: 9]);
					check_field("ratio_r", want.ratio_r, m_tdata[pfd_pkg::O_RR +: 8]);
					check_field("ratio_g", want.ratio_g, m_tdata[pfd_pkg::O_RG +: 8]);
					check_field("ratio_b", want.ratio_b, m_tdata[pfd_pkg::O_RB +: 8]);
					check_field("dist_value", want.dist_value, m_tdata[pfd_pkg::O_DV +: 18]);
					check_field("dist_diff", want.dist_diff, m_tdata[pfd_pkg::O_DD +: 20]);
					check_field("dist_ratio", want.dist_ratio, m_tdata[pfd_pkg::O_DR +: 18]);
					check_field("dist_total", want.dist_total, m_tdata[pfd_pkg::O_DT +: 21]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		ref_rgb[0] = '0;
		ref_rgb[1] = '0;
		ref_rgb[2] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 21;
		recv_idle_pct = 77;

		set_reference(8'd0, 8'd0, 8'd0);
		@(negedge clk);
		add_pixel(8'd0, 8'd0, 8'd0);
		add_pixel(8'd255, 8'd255, 8'd255);
		add_pixel(8'd255, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd255, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd255);
		add_pixel(8'd0, 8'd255, 8'd255);
		add_pixel(8'd255, 8'd0, 8'd255);
		add_pixel(8'd255, 8'd255, 8'd0);
		// Sum of 5 is still dark, 6 is the first with real ratios.
		add_pixel(8'd1, 8'd1, 8'd2);
		add_pixel(8'd1, 8'd1, 8'd3);
		add_pixel(8'd4, 8'd0, 8'd0);
		add_pixel(8'd0, 8'd0, 8'd5);
		add_pixel(8'd255, 8'd255, 8'd160);
		add_pixel(8'd255, 8'd255, 8'd161);
		add_pixel(8'd161, 8'd255, 8'd255);
		add_pixel(8'd255, 8'd160, 8'd255);
		add_pixel(8'd170, 8'd170, 8'd170);
		add_pixel(8'd128, 8'd64, 8'd32);
		add_pixel(8'd1, 8'd254, 8'd127);
		add_pixel(8'd85, 8'd170, 8'd255);
		add_pixel(8'd0, 8'd128, 8'd1);
		wait_idle();

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 3) begin
				send_idle_pct = 21;
				recv_idle_pct = 77;
			end else if (phase < 5) begin
				send_idle_pct = 77;
				recv_idle_pct = 21;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (phase)
				0: set_reference(8'd255, 8'd255, 8'd255);
				1: begin
					// A write to the unused index must leave the reference alone.
					write_reg(REG_UNUSED, 8'($urandom));
					set_reference(8'd2, 8'd1, 8'd1);
				end
				2: set_reference(8'd255, 8'd255, 8'd161);
				3: set_reference(8'd255, 8'd255, 8'd160);
				4: set_reference(8'd0, 8'd255, 8'd0);
				5: set_reference(8'd1, 8'd3, 8'd1);
				default: set_reference(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			@(negedge clk);
			repeat (PHASE_PIXELS) pending_pixels.push_back(random_pixel());
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
